>>> design/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// shared widths, codes and the microcode program of the timer divider search
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int HZ_W   = 32;
    localparam int DEP_W  = 16;
    localparam int PRE_W  = 17;
    localparam int PER_W  = 16;
    localparam int ERR_W  = 14;
    localparam int ST_W   = 2;
    localparam int DVD_W  = 48;   // divider dividend / quotient width
    localparam int CNT_W  = 6;    // divider step counter, holds DVD_W
    localparam int PC_W   = 5;
    localparam int OP_W   = 4;
    localparam int CND_W  = 4;
    localparam int M_W    = HZ_W + ERR_W;

    localparam int MAX_PRESCALE_DEF = 65536;

    localparam logic [HZ_W-1:0]  CLK_HZ_RESET = 32'd16000000;
    localparam logic [ERR_W-1:0] ERR_SCALE    = 14'd10000;

    // divider step counts
    localparam logic [CNT_W-1:0] DIV_N_WORD = 6'd32;
    localparam logic [CNT_W-1:0] DIV_N_WIDE = 6'd48;

    // status codes
    localparam logic [ST_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO_HZ = 2'd2;

    // micro-operations
    localparam logic [OP_W-1:0] UOP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] UOP_LATCH    = 4'd1;
    localparam logic [OP_W-1:0] UOP_DIV_T    = 4'd2;
    localparam logic [OP_W-1:0] UOP_DIV_STEP = 4'd3;
    localparam logic [OP_W-1:0] UOP_ST_T     = 4'd4;
    localparam logic [OP_W-1:0] UOP_DIV_P    = 4'd5;
    localparam logic [OP_W-1:0] UOP_ST_PER   = 4'd6;
    localparam logic [OP_W-1:0] UOP_MUL_PROD = 4'd7;
    localparam logic [OP_W-1:0] UOP_DIV_A    = 4'd8;
    localparam logic [OP_W-1:0] UOP_ST_ACT   = 4'd9;
    localparam logic [OP_W-1:0] UOP_UPD_BEST = 4'd10;
    localparam logic [OP_W-1:0] UOP_INC_P    = 4'd11;
    localparam logic [OP_W-1:0] UOP_MUL_BEST = 4'd12;
    localparam logic [OP_W-1:0] UOP_DIV_E    = 4'd13;
    localparam logic [OP_W-1:0] UOP_EMIT_OK  = 4'd14;
    localparam logic [OP_W-1:0] UOP_EMIT_NF  = 4'd15;

    // jump conditions
    localparam logic [CND_W-1:0] CND_NEVER  = 4'd0;
    localparam logic [CND_W-1:0] CND_ALWAYS = 4'd1;
    localparam logic [CND_W-1:0] CND_NSTART = 4'd2;
    localparam logic [CND_W-1:0] CND_WZERO  = 4'd3;
    localparam logic [CND_W-1:0] CND_DBUSY  = 4'd4;
    localparam logic [CND_W-1:0] CND_PZERO  = 4'd5;
    localparam logic [CND_W-1:0] CND_PGT    = 4'd6;
    localparam logic [CND_W-1:0] CND_NLESS  = 4'd7;
    localparam logic [CND_W-1:0] CND_CLOSE  = 4'd8;
    localparam logic [CND_W-1:0] CND_NPLAST = 4'd9;
    localparam logic [CND_W-1:0] CND_NFOUND = 4'd10;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] PC_LD_T    = 5'd1;
    localparam logic [PC_W-1:0] PC_RUN_T   = 5'd2;
    localparam logic [PC_W-1:0] PC_ST_T    = 5'd3;
    localparam logic [PC_W-1:0] PC_LOOP    = 5'd4;
    localparam logic [PC_W-1:0] PC_RUN_P   = 5'd5;
    localparam logic [PC_W-1:0] PC_ST_PER  = 5'd6;
    localparam logic [PC_W-1:0] PC_CHK_PER = 5'd7;
    localparam logic [PC_W-1:0] PC_MUL     = 5'd8;
    localparam logic [PC_W-1:0] PC_LD_A    = 5'd9;
    localparam logic [PC_W-1:0] PC_RUN_A   = 5'd10;
    localparam logic [PC_W-1:0] PC_ST_ACT  = 5'd11;
    localparam logic [PC_W-1:0] PC_CMP     = 5'd12;
    localparam logic [PC_W-1:0] PC_CHK_CL  = 5'd13;
    localparam logic [PC_W-1:0] PC_NEXT_P  = 5'd14;
    localparam logic [PC_W-1:0] PC_FIN     = 5'd15;
    localparam logic [PC_W-1:0] PC_LD_E    = 5'd16;
    localparam logic [PC_W-1:0] PC_RUN_E   = 5'd17;
    localparam logic [PC_W-1:0] PC_EM_OK   = 5'd18;
    localparam logic [PC_W-1:0] PC_EM_NF   = 5'd19;
    localparam logic [PC_W-1:0] PC_EM_Z    = 5'd20;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // control store: one word per step, jump to target when cond holds
    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        begin
            case (pc)
                PC_IDLE:    w = '{UOP_LATCH,    CND_NSTART, PC_IDLE};
                PC_LD_T:    w = '{UOP_DIV_T,    CND_WZERO,  PC_EM_Z};
                PC_RUN_T:   w = '{UOP_DIV_STEP, CND_DBUSY,  PC_RUN_T};
                PC_ST_T:    w = '{UOP_ST_T,     CND_NEVER,  PC_IDLE};
                PC_LOOP:    w = '{UOP_DIV_P,    CND_NEVER,  PC_IDLE};
                PC_RUN_P:   w = '{UOP_DIV_STEP, CND_DBUSY,  PC_RUN_P};
                PC_ST_PER:  w = '{UOP_ST_PER,   CND_NEVER,  PC_IDLE};
                PC_CHK_PER: w = '{UOP_NOP,      CND_PZERO,  PC_FIN};
                PC_MUL:     w = '{UOP_MUL_PROD, CND_PGT,    PC_NEXT_P};
                PC_LD_A:    w = '{UOP_DIV_A,    CND_NEVER,  PC_IDLE};
                PC_RUN_A:   w = '{UOP_DIV_STEP, CND_DBUSY,  PC_RUN_A};
                PC_ST_ACT:  w = '{UOP_ST_ACT,   CND_NEVER,  PC_IDLE};
                PC_CMP:     w = '{UOP_UPD_BEST, CND_NLESS,  PC_NEXT_P};
                PC_CHK_CL:  w = '{UOP_NOP,      CND_CLOSE,  PC_FIN};
                PC_NEXT_P:  w = '{UOP_INC_P,    CND_NPLAST, PC_LOOP};
                PC_FIN:     w = '{UOP_MUL_BEST, CND_NFOUND, PC_EM_NF};
                PC_LD_E:    w = '{UOP_DIV_E,    CND_NEVER,  PC_IDLE};
                PC_RUN_E:   w = '{UOP_DIV_STEP, CND_DBUSY,  PC_RUN_E};
                PC_EM_OK:   w = '{UOP_EMIT_OK,  CND_ALWAYS, PC_IDLE};
                PC_EM_NF:   w = '{UOP_EMIT_NF,  CND_ALWAYS, PC_IDLE};
                PC_EM_Z:    w = '{UOP_EMIT_NF,  CND_ALWAYS, PC_IDLE};
                default:    w = '{UOP_NOP,      CND_ALWAYS, PC_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

>>> design/timer_divider_search_top.sv
// ----------------------------------------------------------------------------
// timer_divider_search_top
// prescaler / period search for a timer tick, run by a microcoded sequencer
// ----------------------------------------------------------------------------
// A request (start high while busy is low) carries a wanted tick frequency and
// a counter depth. The block forms total = clock / wanted and walks prescalers
// p = 1, 2, ... up to MAX_PRESCALE, keeping the first (p, period) pair with the
// smallest frequency error below 100 percent; it stops early once the error is
// under 0.01 percent or total / p reaches zero. Exactly one result comes back
// per request on o_valid for a single cycle, and it cannot be held off, so the
// receiver must take it when it appears. All divisions share one restoring
// divider that retires one quotient bit per cycle. It first divides the clock
// by the wanted frequency, then for each prescaler divides total by p for the
// period; a period beyond the counter depth is skipped, and one that fits has
// the clock divided by p * period for the actual frequency, which is then
// compared with the best so far; a zero period ends the search. Last, when a
// pair was found, the error figure is divided out, and the result strobe
// follows. A request with a zero wanted frequency skips the search entirely.
// The clock register is written over its own valid / ready channel; ready is
// low while a search runs, so the register only changes between requests.
// ----------------------------------------------------------------------------
module timer_divider_search_top #(
    parameter int MAX_PRESCALE = tds_pkg::MAX_PRESCALE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request side
    input  logic                       start,
    output logic                       busy,
    input  logic [tds_pkg::HZ_W-1:0]   i_wanted_hz,
    input  logic [tds_pkg::DEP_W-1:0]  i_counter_depth,
    // result side
    output logic                       o_valid,
    output logic [tds_pkg::PRE_W-1:0]  o_prescale_value,
    output logic [tds_pkg::PER_W-1:0]  o_period_value,
    output logic [tds_pkg::HZ_W-1:0]   o_actual_hz,
    output logic [tds_pkg::ERR_W-1:0]  o_error_hundredths,
    output logic [tds_pkg::ST_W-1:0]   o_status,
    // clock register write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tds_pkg::HZ_W-1:0]   i_cfg_data
);

    localparam logic [tds_pkg::PRE_W-1:0] P_LAST = tds_pkg::PRE_W'(MAX_PRESCALE);

    // sequencer
    logic [tds_pkg::PC_W-1:0]  r_pc;
    logic [tds_pkg::PC_W-1:0]  n_pc;
    tds_pkg::t_uword           w_uw;
    logic                      w_take;

    // clock register and latched request
    logic [tds_pkg::HZ_W-1:0]  r_clk_hz;
    logic [tds_pkg::HZ_W-1:0]  r_wanted;
    logic [tds_pkg::DEP_W-1:0] r_depth;

    // shared restoring divider
    logic [tds_pkg::DVD_W-1:0] r_dq;     // dividend out at the top, quotient in at the bottom
    logic [tds_pkg::HZ_W-1:0]  r_rem;
    logic [tds_pkg::HZ_W-1:0]  r_dv;
    logic [tds_pkg::CNT_W-1:0] r_dcnt;
    logic [tds_pkg::HZ_W:0]    w_trial;
    logic [tds_pkg::HZ_W:0]    w_sub;
    logic                      w_ge;
    logic [tds_pkg::HZ_W-1:0]  w_q32;

    // search datapath
    logic [tds_pkg::HZ_W-1:0]  r_total;
    logic [tds_pkg::PRE_W-1:0] r_p;
    logic [tds_pkg::HZ_W-1:0]  r_per;
    logic [tds_pkg::HZ_W-1:0]  r_prod;
    logic [tds_pkg::HZ_W:0]    w_prod_full;
    logic [tds_pkg::HZ_W-1:0]  r_act;
    logic [tds_pkg::HZ_W-1:0]  r_diff;
    logic [tds_pkg::HZ_W-1:0]  r_best_diff;
    logic [tds_pkg::PRE_W-1:0] r_best_pre;
    logic [tds_pkg::PER_W-1:0] r_best_per;
    logic [tds_pkg::HZ_W-1:0]  r_best_act;
    logic                      r_found;
    logic [tds_pkg::M_W-1:0]   r_m;      // error term scaled by 10000
    logic                      w_less;

    assign busy        = (r_pc != tds_pkg::PC_IDLE);
    assign o_cfg_ready = !busy;          // register only changes between requests

    assign w_uw = tds_pkg::f_ucode(r_pc);

    // one quotient bit per cycle
    assign w_trial = {r_rem, r_dq[tds_pkg::DVD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dv};
    assign w_ge    = (w_trial >= {1'b0, r_dv});
    assign w_q32   = r_dq[tds_pkg::HZ_W-1:0];

    // p * period stays below 2^32 whenever the period fits the counter
    assign w_prod_full = {{(tds_pkg::HZ_W + 1 - tds_pkg::PRE_W){1'b0}}, r_p}
                       * {{(tds_pkg::HZ_W + 1 - tds_pkg::PER_W){1'b0}},
                          r_per[tds_pkg::PER_W-1:0]};
    assign w_less      = (r_diff < r_best_diff);

    // jump condition, evaluated on the registers and the start input of the current step
    always_comb begin
        case (w_uw.cond)
            tds_pkg::CND_NEVER:  w_take = 1'b0;
            tds_pkg::CND_ALWAYS: w_take = 1'b1;
            tds_pkg::CND_NSTART: w_take = !start;
            tds_pkg::CND_WZERO:  w_take = (r_wanted == '0);
            tds_pkg::CND_DBUSY:  w_take = (r_dcnt != tds_pkg::CNT_W'(1));
            tds_pkg::CND_PZERO:  w_take = (r_per == '0);
            tds_pkg::CND_PGT:    w_take = (r_per > {16'b0, r_depth});
            tds_pkg::CND_NLESS:  w_take = !w_less;
            tds_pkg::CND_CLOSE:  w_take = (r_m < {{tds_pkg::ERR_W{1'b0}}, r_wanted});
            tds_pkg::CND_NPLAST: w_take = (r_p != P_LAST);
            tds_pkg::CND_NFOUND: w_take = !r_found;
            default:             w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + tds_pkg::PC_W'(1);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= tds_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // result strobe and clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid  <= 1'b0;
            r_clk_hz <= tds_pkg::CLK_HZ_RESET;
        end else begin
            o_valid <= (w_uw.op == tds_pkg::UOP_EMIT_OK) || (w_uw.op == tds_pkg::UOP_EMIT_NF);
            if (i_cfg_valid && o_cfg_ready) begin
                r_clk_hz <= i_cfg_data;
            end
        end
    end

    // plain datapath driven by the control word
    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            tds_pkg::UOP_LATCH: begin
                if (start) begin
                    r_wanted <= i_wanted_hz;
                    r_depth  <= i_counter_depth;
                end
            end
            tds_pkg::UOP_DIV_T: begin
                r_dq   <= {r_clk_hz, 16'b0};
                r_dv   <= r_wanted;
                r_rem  <= '0;
                r_dcnt <= tds_pkg::DIV_N_WORD;
            end
            tds_pkg::UOP_DIV_STEP: begin
                r_rem  <= w_ge ? w_sub[tds_pkg::HZ_W-1:0] : w_trial[tds_pkg::HZ_W-1:0];
                r_dq   <= {r_dq[tds_pkg::DVD_W-2:0], w_ge};
                r_dcnt <= r_dcnt - tds_pkg::CNT_W'(1);
            end
            tds_pkg::UOP_ST_T: begin
                r_total     <= w_q32;
                r_p         <= tds_pkg::PRE_W'(1);
                r_best_diff <= r_wanted;   // acceptance bound, below 100 percent
                r_found     <= 1'b0;
            end
            tds_pkg::UOP_DIV_P: begin
                r_dq   <= {r_total, 16'b0};
                r_dv   <= {15'b0, r_p};
                r_rem  <= '0;
                r_dcnt <= tds_pkg::DIV_N_WORD;
            end
            tds_pkg::UOP_ST_PER: begin
                r_per <= w_q32;
            end
            tds_pkg::UOP_MUL_PROD: begin
                r_prod <= w_prod_full[tds_pkg::HZ_W-1:0];
            end
            tds_pkg::UOP_DIV_A: begin
                r_dq   <= {r_clk_hz, 16'b0};
                r_dv   <= r_prod;
                r_rem  <= '0;
                r_dcnt <= tds_pkg::DIV_N_WORD;
            end
            tds_pkg::UOP_ST_ACT: begin
                r_act  <= w_q32;
                r_diff <= (w_q32 >= r_wanted) ? (w_q32 - r_wanted) : (r_wanted - w_q32);
            end
            tds_pkg::UOP_UPD_BEST: begin
                if (w_less) begin
                    r_best_diff <= r_diff;
                    r_best_pre  <= r_p;
                    r_best_per  <= r_per[tds_pkg::PER_W-1:0];
                    r_best_act  <= r_act;
                    r_found     <= 1'b1;
                end
                r_m <= {{tds_pkg::ERR_W{1'b0}}, r_diff}
                     * {{tds_pkg::HZ_W{1'b0}}, tds_pkg::ERR_SCALE};
            end
            tds_pkg::UOP_INC_P: begin
                r_p <= r_p + tds_pkg::PRE_W'(1);
            end
            tds_pkg::UOP_MUL_BEST: begin
                r_m <= {{tds_pkg::ERR_W{1'b0}}, r_best_diff}
                     * {{tds_pkg::HZ_W{1'b0}}, tds_pkg::ERR_SCALE};
            end
            tds_pkg::UOP_DIV_E: begin
                r_dq   <= {{(tds_pkg::DVD_W - tds_pkg::M_W){1'b0}}, r_m};
                r_dv   <= r_wanted;
                r_rem  <= '0;
                r_dcnt <= tds_pkg::DIV_N_WIDE;
            end
            tds_pkg::UOP_EMIT_OK: begin
                o_prescale_value   <= r_best_pre;
                o_period_value     <= r_best_per;
                o_actual_hz        <= r_best_act;
                o_error_hundredths <= r_dq[tds_pkg::ERR_W-1:0];  // quotient below 10000
                o_status           <= tds_pkg::ST_FOUND;
            end
            tds_pkg::UOP_EMIT_NF: begin
                // nothing fits, or a zero wanted frequency
                o_prescale_value   <= tds_pkg::PRE_W'(1);
                o_period_value     <= tds_pkg::PER_W'(1);
                o_actual_hz        <= '0;
                o_error_hundredths <= tds_pkg::ERR_SCALE;
                o_status           <= (r_wanted == '0) ? tds_pkg::ST_ZERO_HZ
                                                       : tds_pkg::ST_NOFIT;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // a result strobe lasts one cycle, and the block is already idle while it is high
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe not a single cycle at the end of a search");

    // an accepted request always leaves idle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but sequencer stayed idle");

    // a found result has an error below 100 percent
    a_found_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == tds_pkg::ST_FOUND) |-> o_error_hundredths < tds_pkg::ERR_SCALE)
        else $error("found result with error of 100 percent or more");

    // divider never steps past its count
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.op == tds_pkg::UOP_DIV_STEP) |-> r_dcnt != '0)
        else $error("divider stepped with an exhausted count");

endmodule
